FILE: rtl/rsao_pkg.sv
// ----------------------------------------------------------------------------
// rsao_pkg
// Types and constants shared by the rectangle set overlap block.
// ----------------------------------------------------------------------------
package rsao_pkg;

  localparam int MAX_REFS    = 256;
  localparam int COORD_WIDTH = 32;
  localparam int FIELD_WIDTH = 32;

  localparam int CNT_W  = $clog2(MAX_REFS + 1);
  localparam int ADDR_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]                    kind;
    logic signed [FIELD_WIDTH-1:0] left_x;
    logic signed [FIELD_WIDTH-1:0] bottom_y;
    logic signed [FIELD_WIDTH-1:0] right_x;
    logic signed [FIELD_WIDTH-1:0] top_y;
  } in_t;

  typedef struct packed {
    logic hit;
    logic dropped;
  } out_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x1;
    logic signed [COORD_WIDTH-1:0] y1;
    logic signed [COORD_WIDTH-1:0] x2;
    logic signed [COORD_WIDTH-1:0] y2;
  } rect_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rect_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    logic match;
  } mem_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  // Keep the low COORD_WIDTH bits; signed compare does the sign extension.
  function automatic rect_t to_rect(in_t w);
    rect_t r;
    r.x1 = w.left_x[COORD_WIDTH-1:0];
    r.y1 = w.bottom_y[COORD_WIDTH-1:0];
    r.x2 = w.right_x[COORD_WIDTH-1:0];
    r.y2 = w.top_y[COORD_WIDTH-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/rsao_refmem.sv
// ----------------------------------------------------------------------------
// rsao_refmem
// Reference rectangle store: one write port, one registered read port, and
// the closed-interval overlap test of the read entry against the query.
// ----------------------------------------------------------------------------
module rsao_refmem
  import rsao_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  input  rect_t    query_i,
  output mem_rsp_t rsp_o
);

  rect_t mem_q [MAX_REFS];
  rect_t rd_data_q;
  logic  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= req_i.re;
    end
  end

  // Touching edges count as overlap.
  always_comb begin
    rsp_o.valid = rd_valid_q;
    rsp_o.match = !((query_i.x2 < rd_data_q.x1) || (rd_data_q.x2 < query_i.x1) ||
                    (query_i.y2 < rd_data_q.y1) || (rd_data_q.y2 < query_i.y1));
  end

endmodule

FILE: rtl/rect_set_any_overlap_top.sv
// ----------------------------------------------------------------------------
// rect_set_any_overlap_top
// Keeps a set of reference rectangles and answers whether a query rectangle
// overlaps any of them.
//
//   channel  dir  handshake                payload
//   in       in   in_valid_i / in_stall_o   in_data_i  (in_t)
//   out      out  out_valid_o / out_stall_i out_data_o (out_t)
//
// Clear, add and unused kinds: an accepted word goes to the response state
// and its result is then loaded into the output register. A query reads one
// stored entry per cycle from the single memory read port and ends at the
// first hit or after the last stored entry. One word is in work at a time;
// the output register holds a finished result so the next word can be taken
// meanwhile. Reset empties the set; the memory needs no clearing.
// ----------------------------------------------------------------------------
module rect_set_any_overlap_top
  import rsao_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  rect_t            query_q, query_d;
  out_t             res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  logic in_acc;
  logic set_full;
  logic hit_now;
  logic scan_done;
  logic out_free;

  rsao_refmem u_refmem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .query_i(query_q),
    .rsp_o  (mem_rsp)
  );

  assign in_acc    = in_valid_i && !in_stall_o;
  assign set_full  = (count_q >= CNT_W'(MAX_REFS));
  assign hit_now   = mem_rsp.valid && mem_rsp.match;
  assign scan_done = hit_now || ((issue_q == count_q) && !mem_rsp.valid);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin : next_state
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_data_i.kind == KIND_QUERY) ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Writes happen only in idle and reads only in scan, so the memory never
  // sees a read and a write to the same entry in flight.
  always_comb begin : fsm_outputs
    in_stall_o    = (state_q != S_IDLE);
    mem_req.we    = (state_q == S_IDLE) && in_acc &&
                    (in_data_i.kind == KIND_ADD) && !set_full;
    mem_req.waddr = count_q[ADDR_W-1:0];
    mem_req.wdata = to_rect(in_data_i);
    mem_req.re    = (state_q == S_SCAN) && (issue_q < count_q) && !hit_now;
    mem_req.raddr = issue_q[ADDR_W-1:0];
  end

  always_comb begin : datapath
    count_d     = count_q;
    issue_d     = issue_q;
    query_d     = query_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          query_d     = to_rect(in_data_i);
          issue_d     = '0;
          res_d.hit   = 1'b0;
          res_d.dropped = (in_data_i.kind == KIND_ADD) && set_full;
          if (in_data_i.kind == KIND_CLEAR) begin
            count_d = '0;
          end else if (mem_req.we) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        if (mem_req.re) begin
          issue_d = issue_q + CNT_W'(1);
        end
        if (scan_done) begin
          res_d.hit     = hit_now;
          res_d.dropped = 1'b0;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q <= query_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_REFS))
    else $error("reference count above capacity");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("memory read and write in the same cycle");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (issue_q <= count_q))
    else $error("scan index past the stored count");

  a_query_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.kind == KIND_QUERY)) |=> (state_q == S_SCAN))
    else $error("accepted query did not start a scan");
`endif

endmodule
